>>> src/vrl_pkg.sv
// Shared types and constants for the vector rescale-to-length block.
package vrl_pkg;

    localparam int CW = 16;
    localparam int TGT_W = CW - 1;
    localparam int SQ_W = 2 * CW - 1;
    localparam int NUM_W = 2 * CW - 2;
    localparam int SUM_W = 2 * CW;
    localparam int LEN_W = CW;
    localparam int Q_W = CW - 1;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [CW-1:0] comp_x;
        logic signed [CW-1:0] comp_y;
        logic signed [CW-1:0] comp_z;
        logic [TGT_W-1:0]     target_length;
    } vrl_req_t;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
        logic [LEN_W-1:0]     input_length;
        logic                 zero_vector;
    } vrl_res_t;

    typedef struct packed {
        logic [2:0][SQ_W-1:0]  sq;
        logic [2:0][NUM_W-1:0] num;
        logic [2:0]            neg;
        logic                  zero;
    } vrl_item_t;

    typedef struct packed {
        logic [2:0][NUM_W-1:0] num;
        logic [2:0]            neg;
        logic                  zero;
    } vrl_side_t;

    typedef struct packed {
        logic [2:0][NUM_W-1:0] rem;
        logic [2:0][Q_W-1:0]   quo;
        logic [LEN_W-1:0]      len;
        logic [2:0]            neg;
        logic                  zero;
    } vrl_div_t;

endpackage

>>> src/vrl_front.sv
// Front stage: takes requests, forms magnitudes, squares and scaled numerators.
module vrl_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  vrl_pkg::vrl_req_t  req_data,
    output logic               item_valid,
    input  logic               item_ready,
    output vrl_pkg::vrl_item_t item_data
);
    import vrl_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    vrl_item_t           item_reg;
    vrl_item_t           item_next;
    logic [2:0][CW-1:0]  raw;
    logic [2:0][CW-1:0]  mag;
    logic                accept;

    assign req_ready = !valid_reg || item_ready;
    assign accept = req_valid && req_ready;
    assign raw[0] = req_data.comp_x;
    assign raw[1] = req_data.comp_y;
    assign raw[2] = req_data.comp_z;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            item_next.neg[l] = raw[l][CW-1];
            mag[l] = raw[l][CW-1] ? (~raw[l] + CW'(1)) : raw[l];
            item_next.sq[l] = SQ_W'(mag[l] * mag[l]);
            item_next.num[l] = NUM_W'(mag[l] * req_data.target_length);
        end
        item_next.zero = (raw == '0);
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item_data = item_reg;

endmodule

>>> src/vrl_queue.sv
// Short queue between the front stage and the arithmetic pipeline.
module vrl_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  vrl_pkg::vrl_item_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output vrl_pkg::vrl_item_t pop_data
);
    import vrl_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vrl_item_t         mem_reg [DEPTH];
    logic [PW-1:0]     wr_reg;
    logic [PW-1:0]     wr_next;
    logic [PW-1:0]     rd_reg;
    logic [PW-1:0]     rd_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              push;
    logic              pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign push = push_valid && push_ready;
    assign pop = pop_valid && pop_ready;
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

>>> src/vrl_back.sv
// Back pipeline: sum of squares, bit-per-stage square root and division, output register.
module vrl_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  vrl_pkg::vrl_item_t item_data,
    output logic               res_valid,
    input  logic               res_ready,
    output vrl_pkg::vrl_res_t  res_data
);
    import vrl_pkg::*;

    localparam int SQS = LEN_W;
    localparam int DVS = Q_W;

    logic                en;
    logic [SQS:0]        sv_reg;
    logic [SUM_W-1:0]    srem_reg [SQS+1];
    logic [LEN_W-1:0]    sroot_reg [SQS+1];
    vrl_side_t           sside_reg [SQS+1];
    logic [DVS:0]        dv_reg;
    vrl_div_t            d_reg [DVS+1];
    logic                res_valid_reg;
    vrl_res_t            res_reg;
    vrl_res_t            res_next;
    vrl_div_t            d_last;

    assign en = !res_valid_reg || res_ready;
    assign item_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= '0;
            dv_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sv_reg <= {sv_reg[SQS-1:0], item_valid};
            dv_reg <= {dv_reg[DVS-1:0], sv_reg[SQS]};
            res_valid_reg <= dv_reg[DVS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srem_reg[0] <= SUM_W'(item_data.sq[0]) + SUM_W'(item_data.sq[1])
                         + SUM_W'(item_data.sq[2]);
            sroot_reg[0] <= '0;
            sside_reg[0].num <= item_data.num;
            sside_reg[0].neg <= item_data.neg;
            sside_reg[0].zero <= item_data.zero;
        end
    end

    for (genvar k = 0; k < SQS; k++)
    begin : g_sqrt
        localparam int I = SQS - 1 - k;
        logic [SUM_W:0]   cand;
        logic [SUM_W:0]   rem_ext;
        logic [SUM_W-1:0] rem_n;
        logic [LEN_W-1:0] root_n;

        always_comb
        begin
            cand = ((SUM_W+1)'(sroot_reg[k]) << (I + 1)) + ((SUM_W+1)'(1) << (2 * I));
            rem_ext = {1'b0, srem_reg[k]};
            if (rem_ext >= cand)
            begin
                rem_n = SUM_W'(rem_ext - cand);
                root_n = sroot_reg[k] | (LEN_W'(1) << I);
            end
            else
            begin
                rem_n = srem_reg[k];
                root_n = sroot_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                srem_reg[k+1] <= rem_n;
                sroot_reg[k+1] <= root_n;
                sside_reg[k+1] <= sside_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0].rem <= sside_reg[SQS].num;
            d_reg[0].quo <= '0;
            d_reg[0].len <= sroot_reg[SQS];
            d_reg[0].neg <= sside_reg[SQS].neg;
            d_reg[0].zero <= sside_reg[SQS].zero;
        end
    end

    for (genvar j = 0; j < DVS; j++)
    begin : g_div
        localparam int B = DVS - 1 - j;
        logic [NUM_W-1:0] dvs;
        vrl_div_t         dn;

        always_comb
        begin
            dvs = NUM_W'(d_reg[j].len) << B;
            dn = d_reg[j];
            for (int l = 0; l < 3; l++)
            begin
                if (d_reg[j].rem[l] >= dvs)
                begin
                    dn.rem[l] = d_reg[j].rem[l] - dvs;
                    dn.quo[l] = d_reg[j].quo[l] | (Q_W'(1) << B);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[j+1] <= dn;
            end
        end
    end

    always_comb
    begin
        d_last = d_reg[DVS];
        if (d_last.zero)
        begin
            res_next = '0;
            res_next.zero_vector = 1'b1;
        end
        else
        begin
            res_next.out_x = d_last.neg[0] ? -CW'(d_last.quo[0]) : CW'(d_last.quo[0]);
            res_next.out_y = d_last.neg[1] ? -CW'(d_last.quo[1]) : CW'(d_last.quo[1]);
            res_next.out_z = d_last.neg[2] ? -CW'(d_last.quo[2]) : CW'(d_last.quo[2]);
            res_next.input_length = d_last.len;
            res_next.zero_vector = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data = res_reg;

endmodule

>>> src/vector_rescale_to_length_unit.sv
// Top level of the vector rescale-to-length unit.
// One request per clock is taken and one result per clock is given when the result side is ready.
// From acceptance to its result a request passes the front register, the queue, the sum-of-squares
// register, 16 square-root stages that each settle one bit of the length, the divider load
// register, a division stage for each quotient bit that settles that bit for all three components,
// and the output register. A zero vector gives zero components, a zero length and the zero flag
// set.
module vector_rescale_to_length_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  vrl_pkg::vrl_req_t req_data,
    output logic              res_valid,
    input  logic              res_ready,
    output vrl_pkg::vrl_res_t res_data
);
    import vrl_pkg::*;

    logic      f_valid;
    logic      f_ready;
    vrl_item_t f_data;
    logic      b_valid;
    logic      b_ready;
    vrl_item_t b_data;

    vrl_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item_data  (f_data)
    );

    vrl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    vrl_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (b_valid),
        .item_ready (b_ready),
        .item_data  (b_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.zero_vector |->
            res_data.input_length == '0 && res_data.out_x == '0
            && res_data.out_y == '0 && res_data.out_z == '0)
        else $error("zero vector result carries nonzero fields");

    a_nonzero_length: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.zero_vector |-> res_data.input_length != '0)
        else $error("nonzero vector result has zero length");

    a_no_min_value: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.out_x != {1'b1, {(CW-1){1'b0}}}
            && res_data.out_y != {1'b1, {(CW-1){1'b0}}}
            && res_data.out_z != {1'b1, {(CW-1){1'b0}}})
        else $error("scaled component exceeds target range");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the vector rescale-to-length unit.
`timescale 1ns / 100ps

module testbench;
    import vrl_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_REQUESTS = 1800;

    class rescale_scoreboard;
        vrl_res_t pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        static function longint unsigned floor_sqrt(longint unsigned n);
            longint unsigned root;
            longint unsigned probe;
            root = 0;
            for (int b = 31; b >= 0; b--)
            begin
                probe = root | (64'd1 << b);
                if (probe * probe <= n)
                    root = probe;
            end
            return root;
        endfunction

        static function vrl_res_t rescale(vrl_req_t r);
            vrl_res_t res;
            longint signed comp[3];
            longint unsigned mag[3];
            longint unsigned sum;
            longint unsigned len;
            longint unsigned quo;
            logic [CW-1:0] outs[3];
            comp[0] = r.comp_x;
            comp[1] = r.comp_y;
            comp[2] = r.comp_z;
            sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] = comp[i] < 0 ? -comp[i] : comp[i];
                sum += mag[i] * mag[i];
            end
            len = floor_sqrt(sum);
            res = '0;
            if (len == 0)
            begin
                res.zero_vector = 1'b1;
                return res;
            end
            for (int i = 0; i < 3; i++)
            begin
                quo = (mag[i] * longint'(r.target_length)) / len;
                outs[i] = comp[i] < 0 ? CW'(-quo) : CW'(quo);
            end
            res.out_x = outs[0];
            res.out_y = outs[1];
            res.out_z = outs[2];
            res.input_length = len[CW-1:0];
            return res;
        endfunction

        function void note_request(vrl_req_t r);
            pending.push_back(rescale(r));
        endfunction

        function void check_result(vrl_res_t got);
            vrl_res_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.out_x !== want.out_x)
                report("out_x", want.out_x, got.out_x);
            if (got.out_y !== want.out_y)
                report("out_y", want.out_y, got.out_y);
            if (got.out_z !== want.out_z)
                report("out_z", want.out_z, got.out_z);
            if (got.input_length !== want.input_length)
                report("input_length", want.input_length, got.input_length);
            if (got.zero_vector !== want.zero_vector)
                report("zero_vector", want.zero_vector, got.zero_vector);
        endfunction

        function void report(string field, logic [CW-1:0] want, logic [CW-1:0] got);
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
            errors++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    vrl_req_t req_data;
    logic res_valid;
    logic res_ready;
    vrl_res_t res_data;

    rescale_scoreboard board;
    int idle_cycles;

    vector_rescale_to_length_unit uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data(req_data),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_data(res_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [CW-1:0] random_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return CW'($urandom_range(0, 8)) - 16'd4;
            3: return CW'($urandom_range(0, 600)) - 16'd300;
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic logic [TGT_W-1:0] random_target();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return TGT_W'(1 << $urandom_range(0, 14));
            default: return TGT_W'($urandom);
        endcase
    endfunction

    task automatic send_request(vrl_req_t r);
        req_data <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        board.note_request(r);
        @(negedge clk);
    endtask

    task automatic send_vector(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                               logic [TGT_W-1:0] t);
        vrl_req_t r;
        r.comp_x = x;
        r.comp_y = y;
        r.comp_z = z;
        r.target_length = t;
        send_request(r);
    endtask

    task automatic pause_sender(int cycles);
        req_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            board.check_result(res_data);
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else if (($time / 5000) % 3 == 2)
            res_ready <= 1'b1;
        else
            res_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int burst;
        int drain;
        board = new();
        idle_cycles = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_vector(16'd0, 16'd0, 16'd0, 15'd100);
        send_vector(16'd0, 16'd0, 16'd0, 15'd0);
        send_vector(16'd3, 16'd4, 16'd0, 15'd0);
        send_vector(16'd1, 16'd0, 16'd0, 15'h7fff);
        send_vector(16'h8000, 16'h8000, 16'h8000, 15'h7fff);
        send_vector(16'h7fff, 16'h7fff, 16'h7fff, 15'h7fff);
        send_vector(16'h8000, 16'd0, 16'd0, 15'd256);
        send_vector(16'd0, 16'h7fff, 16'd0, 15'd256);
        send_vector(16'd0, 16'd0, 16'hffff, 15'd1);
        send_vector(16'hfffd, 16'd4, 16'd12, 15'd13);
        send_vector(16'd5555, 16'hffff, 16'd7, 15'h5555);
        send_vector(16'h2aaa, 16'h5555, 16'haaaa, 15'h2aaa);

        pause_sender(1);
        while (board.pending.size() != 0)
            @(negedge clk);

        for (int n = 0; n < RANDOM_REQUESTS; )
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < RANDOM_REQUESTS; k++, n++)
                send_vector(random_comp(), random_comp(), random_comp(), random_target());
            if ($urandom_range(0, 2) == 0)
                pause_sender($urandom_range(1, 12));
        end
        req_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(negedge clk);
        drain = 0;
        while (drain < DRAIN_CYCLES)
        begin
            @(negedge clk);
            drain++;
        end
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> sim.f
src/vrl_pkg.sv
src/vrl_front.sv
src/vrl_queue.sv
src/vrl_back.sv
src/vector_rescale_to_length_unit.sv
verif/testbench.sv
